// File: rtl/ossc_pkg.sv
// ----------------------------------------------------------------------------
// Obstacle steer slew controller package
// Field widths, steering constants, command and register index codes.
// ----------------------------------------------------------------------------
package ossc_pkg;

  localparam int unsigned PWM_W      = 11;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned CX_W       = 10;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TGT_W      = 28;
  localparam int unsigned DIFF_W     = 29;
  localparam int unsigned NEXT_W     = 21;
  localparam int unsigned ERR_W      = 11;
  localparam int unsigned PROD_W     = 27;
  localparam int unsigned OFS_W      = 13;

  localparam logic [PWM_W-1:0]  PWM_LEFT      = 11'd1840;
  localparam logic [PWM_W-1:0]  PWM_RIGHT     = 11'd1560;
  localparam logic [PWM_W-1:0]  PWM_MIN       = 11'd1500;
  localparam logic [PWM_W-1:0]  PWM_MAX       = 11'd1900;
  localparam logic [PWM_W-1:0]  PWM_RESET     = 11'd1700;
  localparam logic [DIST_W-1:0] NEAR_RESET    = 16'd1500;
  localparam logic [DIST_W-1:0] FOLLOW_RESET  = 16'd4000;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd256;
  localparam logic [DIST_W:0]   FLIP_DELTA_MM = 17'd1200;

  localparam logic signed [ERR_W-1:0]  FRAME_CENTER  = 11'sd320;
  localparam logic signed [OFS_W-1:0]  NO_OBJ_OFFSET = 13'sd100;
  localparam logic signed [DIFF_W-1:0] SLEW_DEAD_Q8  = 29'sd1024;
  localparam logic signed [NEXT_W-1:0] SLEW_STEP     = 21'sd3;

  typedef enum logic {
    CMD_ENTRY = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIDDLE_PWM = 2'd0,
    CFG_NEAR_MM    = 2'd1,
    CFG_FOLLOW_MM  = 2'd2,
    CFG_GAIN_Q8    = 2'd3
  } cfg_idx_t;

endpackage

// File: rtl/obstacle_steer_slew_controller_core.sv
// ----------------------------------------------------------------------------
// Obstacle steer slew controller core
// Nearest obstacle tracking and slew limited steering pulse width per tick.
// An accepted request is held in the request register and its result in the
// result register. Throughput: 1 request per cycle unless a held result stalls
// on out_ready, set by the tick update of the steering state.
// Reset (synchronous, rst_n low): registers to defaults, steering 1700,
// left preference, entry selection empty, both channels empty.
// ----------------------------------------------------------------------------
module obstacle_steer_slew_controller_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ossc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ossc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_cmd,
  input  logic [ossc_pkg::DIST_W-1:0]           in_obj_distance_mm,
  input  logic [ossc_pkg::CX_W-1:0]             in_obj_center_x,
  input  logic                                  in_auto_mode,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ossc_pkg::PWM_W-1:0]            out_steer_pwm,
  output logic                                  out_turn_left
);

  // configuration
  logic [ossc_pkg::PWM_W-1:0]         middle_pwm_r;
  logic [ossc_pkg::DIST_W-1:0]        near_mm_r;
  logic [ossc_pkg::DIST_W-1:0]        follow_mm_r;
  logic signed [ossc_pkg::GAIN_W-1:0] gain_r;

  // request register
  logic                               req_valid_r;
  logic                               req_cmd_r;
  logic [ossc_pkg::DIST_W-1:0]        req_dist_r;
  logic [ossc_pkg::CX_W-1:0]          req_cx_r;
  logic                               req_auto_r;

  // steering state
  logic [ossc_pkg::PWM_W-1:0]  steer_r, steer_nxt;
  logic [ossc_pkg::DIST_W-1:0] last_dist_r, last_dist_nxt;
  logic                        prefer_left_r, prefer_left_nxt;
  logic [ossc_pkg::PWM_W-1:0]  remembered_r, remembered_nxt;
  logic [ossc_pkg::DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic [ossc_pkg::CX_W-1:0]   best_cx_r, best_cx_nxt;
  logic                        entry_seen_r, entry_seen_nxt;

  // result register
  logic                        out_valid_r;
  logic [ossc_pkg::PWM_W-1:0]  out_pwm_r;
  logic                        out_left_r;

  logic                        is_tick;
  logic                        produces;
  logic                        advance;

  logic [ossc_pkg::DIST_W-1:0]        d_sel;
  logic                               flip;
  logic                               pref_tick;
  logic signed [ossc_pkg::ERR_W-1:0]  err;
  logic signed [ossc_pkg::PROD_W-1:0] err_ext;
  logic signed [ossc_pkg::PROD_W-1:0] gain_ext;
  logic signed [ossc_pkg::PROD_W-1:0] prod;
  logic signed [ossc_pkg::TGT_W-1:0]  follow_q8;
  logic signed [ossc_pkg::TGT_W-1:0]  fixed_q8;
  logic signed [ossc_pkg::OFS_W-1:0]  noobj_tgt;
  logic signed [ossc_pkg::TGT_W-1:0]  noobj_q8;
  logic signed [ossc_pkg::TGT_W-1:0]  target_q8;
  logic                               slew_en;
  logic signed [ossc_pkg::DIFF_W-1:0] diff;
  logic signed [ossc_pkg::NEXT_W-1:0] cur_ext;
  logic signed [ossc_pkg::NEXT_W-1:0] next_raw;
  logic [ossc_pkg::PWM_W-1:0]         slewed;

  assign is_tick  = (req_cmd_r == ossc_pkg::CMD_TICK);
  assign produces = req_valid_r && is_tick && req_auto_r;
  assign advance  = req_valid_r && (!produces || !out_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  // tick arithmetic
  assign d_sel     = (best_dist_r != '0) ? best_dist_r : last_dist_r;
  assign flip      = ({1'b0, d_sel} > ({1'b0, last_dist_r} + ossc_pkg::FLIP_DELTA_MM));
  assign pref_tick = prefer_left_r ^ flip;

  assign err       = ossc_pkg::FRAME_CENTER - $signed({1'b0, best_cx_r});
  assign err_ext   = {{(ossc_pkg::PROD_W-ossc_pkg::ERR_W){err[ossc_pkg::ERR_W-1]}}, err};
  assign gain_ext  = {{(ossc_pkg::PROD_W-ossc_pkg::GAIN_W){gain_r[ossc_pkg::GAIN_W-1]}},
                      gain_r};
  assign prod      = err_ext * gain_ext;
  assign follow_q8 = $signed({9'b0, middle_pwm_r, 8'b0})
                   + $signed({prod[ossc_pkg::PROD_W-1], prod});
  assign fixed_q8  = pref_tick ? $signed({9'b0, ossc_pkg::PWM_LEFT, 8'b0})
                               : $signed({9'b0, ossc_pkg::PWM_RIGHT, 8'b0});

  always_comb begin
    noobj_tgt = $signed({2'b0, middle_pwm_r});
    if (remembered_r < middle_pwm_r) begin
      noobj_tgt = $signed({2'b0, middle_pwm_r}) + ossc_pkg::NO_OBJ_OFFSET;
    end else if (remembered_r > middle_pwm_r) begin
      noobj_tgt = $signed({2'b0, middle_pwm_r}) - ossc_pkg::NO_OBJ_OFFSET;
    end
  end
  assign noobj_q8 = $signed({{7{noobj_tgt[ossc_pkg::OFS_W-1]}}, noobj_tgt, 8'b0});

  always_comb begin
    slew_en   = 1'b1;
    target_q8 = noobj_q8;
    if (entry_seen_r) begin
      if (d_sel < near_mm_r) begin
        target_q8 = fixed_q8;
      end else if (d_sel < follow_mm_r && d_sel > near_mm_r) begin
        target_q8 = follow_q8;
      end else begin
        slew_en = 1'b0;
      end
    end
  end

  // slew and clamp
  assign diff    = $signed({target_q8[ossc_pkg::TGT_W-1], target_q8})
                 - $signed({10'b0, steer_r, 8'b0});
  assign cur_ext = $signed({10'b0, steer_r});

  always_comb begin
    if (diff > ossc_pkg::SLEW_DEAD_Q8) begin
      next_raw = cur_ext + ossc_pkg::SLEW_STEP;
    end else if (diff < -ossc_pkg::SLEW_DEAD_Q8) begin
      next_raw = cur_ext - ossc_pkg::SLEW_STEP;
    end else begin
      next_raw = $signed({target_q8[ossc_pkg::TGT_W-1], target_q8[ossc_pkg::TGT_W-1:8]});
    end
    if (next_raw > $signed({10'b0, ossc_pkg::PWM_MAX})) begin
      slewed = ossc_pkg::PWM_MAX;
    end else if (next_raw < $signed({10'b0, ossc_pkg::PWM_MIN})) begin
      slewed = ossc_pkg::PWM_MIN;
    end else begin
      slewed = next_raw[ossc_pkg::PWM_W-1:0];
    end
  end

  // state update
  always_comb begin
    steer_nxt       = steer_r;
    last_dist_nxt   = last_dist_r;
    prefer_left_nxt = prefer_left_r;
    remembered_nxt  = remembered_r;
    best_dist_nxt   = best_dist_r;
    best_cx_nxt     = best_cx_r;
    entry_seen_nxt  = entry_seen_r;
    if (advance) begin
      if (!is_tick) begin
        if (!entry_seen_r || (req_dist_r != '0 && req_dist_r < best_dist_r)) begin
          best_dist_nxt  = req_dist_r;
          best_cx_nxt    = req_cx_r;
          entry_seen_nxt = 1'b1;
        end
      end else begin
        entry_seen_nxt = 1'b0;
        if (req_auto_r) begin
          if (slew_en) begin
            steer_nxt = slewed;
          end
          if (entry_seen_r) begin
            prefer_left_nxt = pref_tick;
            last_dist_nxt   = d_sel;
            remembered_nxt  = slew_en ? slewed : steer_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      middle_pwm_r <= ossc_pkg::PWM_RESET;
      near_mm_r    <= ossc_pkg::NEAR_RESET;
      follow_mm_r  <= ossc_pkg::FOLLOW_RESET;
      gain_r       <= ossc_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (ossc_pkg::cfg_idx_t'(cfg_index))
        ossc_pkg::CFG_MIDDLE_PWM: middle_pwm_r <= cfg_data[ossc_pkg::PWM_W-1:0];
        ossc_pkg::CFG_NEAR_MM:    near_mm_r    <= cfg_data;
        ossc_pkg::CFG_FOLLOW_MM:  follow_mm_r  <= cfg_data;
        ossc_pkg::CFG_GAIN_Q8:    gain_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      steer_r       <= ossc_pkg::PWM_RESET;
      last_dist_r   <= '0;
      prefer_left_r <= 1'b1;
      remembered_r  <= ossc_pkg::PWM_RESET;
      best_dist_r   <= '0;
      best_cx_r     <= '0;
      entry_seen_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance && produces) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      steer_r       <= steer_nxt;
      last_dist_r   <= last_dist_nxt;
      prefer_left_r <= prefer_left_nxt;
      remembered_r  <= remembered_nxt;
      best_dist_r   <= best_dist_nxt;
      best_cx_r     <= best_cx_nxt;
      entry_seen_r  <= entry_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd_r  <= in_cmd;
      req_dist_r <= in_obj_distance_mm;
      req_cx_r   <= in_obj_center_x;
      req_auto_r <= in_auto_mode;
    end
    if (advance && produces) begin
      out_pwm_r  <= steer_nxt;
      out_left_r <= prefer_left_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_steer_pwm = out_pwm_r;
  assign out_turn_left = out_left_r;

endmodule

// File: tb/tb_obstacle_steer_slew_controller_core.sv
// ----------------------------------------------------------------------------
// Obstacle steer slew controller core testbench
// Drives obstacle entries and control ticks through a bursty valid/ready
// sender, stalls the result side on a shifting pattern, and checks every
// steering result against a cycle-free model of the nearest-obstacle choice,
// side preference, follow target and slew limited pulse width. Runs several
// register settings, extremes included, each written while the block is idle.
// ----------------------------------------------------------------------------
module tb_obstacle_steer_slew_controller_core;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_REQS     = 200;

  typedef struct {
    ossc_pkg::cmd_t              cmd;
    logic [ossc_pkg::DIST_W-1:0] dist_mm;
    logic [ossc_pkg::CX_W-1:0]   cx;
    logic                        auto_on;
  } steer_req_t;

  typedef struct packed {
    logic [ossc_pkg::PWM_W-1:0] pwm;
    logic                       turn_left;
  } steer_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [ossc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ossc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_cmd = 1'b0;
  logic [ossc_pkg::DIST_W-1:0]     in_obj_distance_mm = '0;
  logic [ossc_pkg::CX_W-1:0]       in_obj_center_x = '0;
  logic                            in_auto_mode = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [ossc_pkg::PWM_W-1:0]      out_steer_pwm;
  logic                            out_turn_left;

  obstacle_steer_slew_controller_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_obj_distance_mm (in_obj_distance_mm),
    .in_obj_center_x    (in_obj_center_x),
    .in_auto_mode       (in_auto_mode),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_steer_pwm      (out_steer_pwm),
    .out_turn_left      (out_turn_left)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Steering model: registers and state
  logic [ossc_pkg::PWM_W-1:0]         m_mid        = ossc_pkg::PWM_RESET;
  logic [ossc_pkg::DIST_W-1:0]        m_near       = ossc_pkg::NEAR_RESET;
  logic [ossc_pkg::DIST_W-1:0]        m_follow     = ossc_pkg::FOLLOW_RESET;
  logic signed [ossc_pkg::GAIN_W-1:0] m_gain       = ossc_pkg::GAIN_RESET;
  logic [ossc_pkg::PWM_W-1:0]         m_steer      = ossc_pkg::PWM_RESET;
  logic [ossc_pkg::DIST_W-1:0]        m_last_dist  = '0;
  logic                               m_prefer_left = 1'b1;
  logic [ossc_pkg::PWM_W-1:0]         m_remembered = ossc_pkg::PWM_RESET;
  logic [ossc_pkg::DIST_W-1:0]        m_best_dist  = '0;
  logic [ossc_pkg::CX_W-1:0]          m_best_cx    = '0;
  logic                               m_entry_seen = 1'b0;

  steer_req_t    pending_reqs[$];
  steer_result_t expected_steer[$];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  bit req_fire       = 1'b0;
  bit res_fire       = 1'b0;
  int burst_left     = 1;
  int gap_left       = 0;
  int stall_hold     = 0;
  logic [15:0] stall_pat = '1;
  int track_dist     = 2500;
  int track_cx       = 320;

  steer_req_t    drv_req;
  steer_req_t    mon_req;
  steer_result_t exp_res;

  function automatic void slew_steer(int target_q8);
    int cur;
    int diff;
    int nxt;
    cur  = int'(m_steer);
    diff = target_q8 - cur * 256;
    if (diff > int'(ossc_pkg::SLEW_DEAD_Q8)) begin
      nxt = cur + int'(ossc_pkg::SLEW_STEP);
    end else if (diff < -int'(ossc_pkg::SLEW_DEAD_Q8)) begin
      nxt = cur - int'(ossc_pkg::SLEW_STEP);
    end else begin
      nxt = target_q8 >>> 8;
    end
    if (nxt > int'(ossc_pkg::PWM_MAX)) nxt = int'(ossc_pkg::PWM_MAX);
    if (nxt < int'(ossc_pkg::PWM_MIN)) nxt = int'(ossc_pkg::PWM_MIN);
    m_steer = nxt[ossc_pkg::PWM_W-1:0];
  endfunction

  task automatic predict_steering(input steer_req_t r);
    int d;
    int mid;
    int target;
    mid = int'(m_mid);
    if (r.cmd == ossc_pkg::CMD_ENTRY) begin
      if (!m_entry_seen || (r.dist_mm != 0 && r.dist_mm < m_best_dist)) begin
        m_best_dist  = r.dist_mm;
        m_best_cx    = r.cx;
        m_entry_seen = 1'b1;
      end
    end else if (!r.auto_on) begin
      m_entry_seen = 1'b0;
    end else begin
      if (m_entry_seen) begin
        d = (m_best_dist != 0) ? int'(m_best_dist) : int'(m_last_dist);
        if (d - int'(m_last_dist) > int'(ossc_pkg::FLIP_DELTA_MM))
          m_prefer_left = ~m_prefer_left;
        m_last_dist = d[ossc_pkg::DIST_W-1:0];
        if (d < int'(m_near)) begin
          slew_steer((m_prefer_left ? int'(ossc_pkg::PWM_LEFT)
                                    : int'(ossc_pkg::PWM_RIGHT)) * 256);
        end else if (d < int'(m_follow) && d > int'(m_near)) begin
          slew_steer(mid * 256
                     + (int'(ossc_pkg::FRAME_CENTER) - int'(m_best_cx)) * int'(m_gain));
        end
        m_remembered = m_steer;
      end else begin
        target = mid;
        if (int'(m_remembered) < mid) target = mid + int'(ossc_pkg::NO_OBJ_OFFSET);
        else if (int'(m_remembered) > mid) target = mid - int'(ossc_pkg::NO_OBJ_OFFSET);
        slew_steer(target * 256);
      end
      m_entry_seen = 1'b0;
      expected_steer.push_back('{pwm: m_steer, turn_left: m_prefer_left});
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Sender: bursts of requests with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        drv_req = pending_reqs.pop_front();
        in_cmd             <= drv_req.cmd;
        in_obj_distance_mm <= drv_req.dist_mm;
        in_obj_center_x    <= drv_req.cx;
        in_auto_mode       <= drv_req.auto_on;
        in_valid           <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: shifting stall pattern, reloaded now and then
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_hold = $urandom_range(16, 96);
      stall_pat  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      stall_hold--;
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
    out_ready <= stall_pat[0];
  end

  // Monitor, checker and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      req_fire = 1'b0;
    end else begin
      req_fire = in_valid && in_ready;
      res_fire = out_valid && out_ready;
      if (req_fire) begin
        mon_req.cmd     = ossc_pkg::cmd_t'(in_cmd);
        mon_req.dist_mm = in_obj_distance_mm;
        mon_req.cx      = in_obj_center_x;
        mon_req.auto_on = in_auto_mode;
        predict_steering(mon_req);
      end
      if (res_fire) begin
        if (expected_steer.size() == 0) begin
          report_mismatch($sformatf("unexpected result pwm %0d turn_left %0b",
                                    out_steer_pwm, out_turn_left));
        end else begin
          exp_res = expected_steer.pop_front();
          if (out_steer_pwm !== exp_res.pwm)
            report_mismatch($sformatf("steer_pwm %0d, model %0d", out_steer_pwm, exp_res.pwm));
          if (out_turn_left !== exp_res.turn_left)
            report_mismatch($sformatf("turn_left %0b, model %0b", out_turn_left,
                                      exp_res.turn_left));
        end
      end
      if (req_fire || res_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  task automatic push_entry(input int dist_v, input int cx);
    pending_reqs.push_back('{cmd: ossc_pkg::CMD_ENTRY, dist_mm: dist_v[ossc_pkg::DIST_W-1:0],
                             cx: cx[ossc_pkg::CX_W-1:0], auto_on: 1'($urandom)});
  endtask

  task automatic push_tick(input logic auto_on);
    pending_reqs.push_back('{cmd: ossc_pkg::CMD_TICK, dist_mm: 16'($urandom),
                             cx: 10'($urandom), auto_on: auto_on});
  endtask

  function automatic int clamp_dist(input int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic int pick_distance();
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1, 2:    v = int'(m_near) + int'($urandom_range(0, 6)) - 3;
      3, 4:    v = int'(m_follow) + int'($urandom_range(0, 6)) - 3;
      5:       v = int'(m_last_dist) + int'($urandom_range(1150, 1250));
      default: v = int'($urandom_range(0, 65535));
    endcase
    return clamp_dist(v);
  endfunction

  task automatic cfg_write(input ossc_pkg::cfg_idx_t idx,
                           input logic [ossc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      ossc_pkg::CFG_MIDDLE_PWM: m_mid    = val[ossc_pkg::PWM_W-1:0];
      ossc_pkg::CFG_NEAR_MM:    m_near   = val;
      ossc_pkg::CFG_FOLLOW_MM:  m_follow = val;
      ossc_pkg::CFG_GAIN_Q8:    m_gain   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int mid, input int near_mm, input int follow_mm,
                            input int gain);
    cfg_write(ossc_pkg::CFG_MIDDLE_PWM, 16'(mid));
    cfg_write(ossc_pkg::CFG_NEAR_MM, 16'(near_mm));
    cfg_write(ossc_pkg::CFG_FOLLOW_MM, 16'(follow_mm));
    cfg_write(ossc_pkg::CFG_GAIN_Q8, 16'(gain));
  endtask

  // Hold until all requests are taken and all results are in, then let
  // any result-free request drain out of the pipeline.
  task automatic wait_idle();
    while (!(pending_reqs.size() == 0 && !in_valid && expected_steer.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_random(input int n);
    int count;
    int k;
    int r;
    int i;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 15);
      if (r < 12) begin
        k = $urandom_range(0, 4);
        if (r < 5 && $urandom_range(0, 7) == 0) begin
          track_dist = pick_distance();
          track_cx   = $urandom_range(0, 1023);
        end
        for (i = 0; i < k; i++) begin
          if (r < 5) begin
            push_entry(clamp_dist(track_dist + int'($urandom_range(0, 40)) - 20),
                       (track_cx + int'($urandom_range(0, 40)) - 20) & 10'h3FF);
          end else begin
            push_entry(pick_distance(), $urandom_range(0, 1023));
          end
        end
        push_tick(1'b1);
        count += k + 1;
      end else if (r < 14) begin
        k = $urandom_range(0, 2);
        for (i = 0; i < k; i++) push_entry(pick_distance(), $urandom_range(0, 1023));
        push_tick(1'b0);
        count += k + 1;
      end else if (r == 14) begin
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++) push_entry(pick_distance(), $urandom_range(0, 1023));
        count += k;
      end else begin
        push_tick(1'($urandom));
        count++;
      end
    end
  endtask

  initial begin
    // Directed requests under reset register values
    push_tick(1'b1);
    push_tick(1'b0);
    push_entry(65535, 1023);
    push_entry(0, 0);
    push_entry(3000, 0);
    push_entry(3500, 600);
    push_tick(1'b1);
    push_entry(0, 1023);
    push_tick(1'b1);
    push_entry(1500, 100);
    push_tick(1'b1);
    push_entry(4000, 100);
    push_tick(1'b1);
    push_entry(100, 320);
    push_tick(1'b1);
    push_entry(1400, 512);
    push_tick(1'b1);
    push_entry(2000, 0);
    push_tick(1'b0);
    push_tick(1'b1);
    push_entry(65535, 1);
    push_tick(1'b1);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_random(PHASE_REQS);
    wait_idle();
    set_config(1000, 0, 65535, -32768);
    push_random(PHASE_REQS);
    wait_idle();
    set_config(2000, 65535, 0, 32767);
    push_random(PHASE_REQS);
    wait_idle();
    set_config(1700, 1500, 4000, -384);
    push_random(PHASE_REQS);
    wait_idle();
    set_config(1500, 800, 6000, 128);
    push_random(PHASE_REQS);
    wait_idle();
    set_config($urandom_range(1000, 2000), $urandom_range(0, 8000),
               $urandom_range(8000, 16000), $urandom_range(0, 65535));
    push_random(PHASE_REQS);
    wait_idle();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
